/* rtl/vna_pkg.sv */
// ============================================================================
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ============================================================================
package vna_pkg;

    localparam int IDX_W = 10;
    localparam int POS_W = 16;
    localparam int NRM_W = 16;
    localparam int THR_W = 40;

    // sum of squares, square root and divider widths
    localparam int SUM_W       = 64;
    localparam int LEN_W       = 33;
    localparam int QUO_W       = 16;
    localparam int SQRT_STEPS  = 32;
    localparam logic [SUM_W-1:0] SQRT_TOP = SUM_W'(1) << 62;
    localparam logic [QUO_W-1:0] ONE_Q14  = QUO_W'(16384);

    // item commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // corner select
    localparam logic [1:0] CRN_A = 2'd0;
    localparam logic [1:0] CRN_B = 2'd1;
    localparam logic [1:0] CRN_C = 2'd2;

    typedef struct packed {
        logic       latch;
        logic       pos_wr;
        logic [1:0] sel;
        logic       pos_cap;
        logic [1:0] cap_sel;
        logic       xmul;
        logic       xsub;
        logic [1:0] k;
        logic       acc_wr;
        logic       mag_cap;
        logic       sq_clr;
        logic       sq_mul;
        logic       sq_add;
        logic       norm_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       res_load;
        logic       res_zero;
    } vna_ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       slot_ok;
        logic       tri_ok;
        logic       big;
        logic       thr_ok;
        logic       norm_done;
        logic       out_free;
    } vna_stat_t;

endpackage

/* rtl/vna_in_if.sv */
// ============================================================================
// vna_in_if
// Item channel: valid/ready with command, slots and position.
// ============================================================================
interface vna_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        cmd;
    logic [vna_pkg::IDX_W-1:0]         index_a;
    logic [vna_pkg::IDX_W-1:0]         index_b;
    logic [vna_pkg::IDX_W-1:0]         index_c;
    logic signed [vna_pkg::POS_W-1:0]  pos_x;
    logic signed [vna_pkg::POS_W-1:0]  pos_y;
    logic signed [vna_pkg::POS_W-1:0]  pos_z;

    modport source (output valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                    input ready);
    modport sink   (input valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                    output ready);
endinterface

/* rtl/vna_out_if.sv */
// ============================================================================
// vna_out_if
// Result channel: valid/ready with slot and unit normal.
// ============================================================================
interface vna_out_if;
    logic                              valid;
    logic                              ready;
    logic [vna_pkg::IDX_W-1:0]         vertex_slot;
    logic signed [vna_pkg::NRM_W-1:0]  normal_x;
    logic signed [vna_pkg::NRM_W-1:0]  normal_y;
    logic signed [vna_pkg::NRM_W-1:0]  normal_z;
    logic                              has_normal;

    modport source (output valid, vertex_slot, normal_x, normal_y, normal_z, has_normal,
                    input ready);
    modport sink   (input valid, vertex_slot, normal_x, normal_y, normal_z, has_normal,
                    output ready);
endinterface

/* rtl/vna_ctrl.sv */
// ============================================================================
// vna_ctrl
// Sequencer: accepts one beat, then steps the datapath through it.
// ============================================================================
module vna_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vna_pkg::vna_stat_t stat,
    output vna_pkg::vna_ctl_t  ctl
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_TPRD  = 5'd2;
    localparam logic [4:0] S_XMUL  = 5'd3;
    localparam logic [4:0] S_XSUB  = 5'd4;
    localparam logic [4:0] S_ARD   = 5'd5;
    localparam logic [4:0] S_AWR   = 5'd6;
    localparam logic [4:0] S_RARD  = 5'd7;
    localparam logic [4:0] S_MAG   = 5'd8;
    localparam logic [4:0] S_SQ1   = 5'd9;
    localparam logic [4:0] S_THR   = 5'd10;
    localparam logic [4:0] S_NORM  = 5'd11;
    localparam logic [4:0] S_SQ2   = 5'd12;
    localparam logic [4:0] S_SQI   = 5'd13;
    localparam logic [4:0] S_SQRT  = 5'd14;
    localparam logic [4:0] S_DIVI  = 5'd15;
    localparam logic [4:0] S_DIV   = 5'd16;
    localparam logic [4:0] S_DIVS  = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;
    localparam logic [4:0] S_ZERO  = 5'd19;

    localparam logic [4:0] CNT_SQRT_LAST = 5'(vna_pkg::SQRT_STEPS - 1);
    localparam logic [4:0] CNT_DIV_LAST  = 5'(vna_pkg::QUO_W - 1);
    localparam logic [4:0] CNT_THREE     = 5'd3;

    logic [4:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cnt_next   = '0;
                k_next     = '0;
                state_next = S_IDLE;
                unique case (stat.cmd)
                    vna_pkg::CMD_LOAD:
                    begin
                        ctl.sel    = vna_pkg::CRN_A;
                        ctl.pos_wr = stat.slot_ok;
                    end
                    vna_pkg::CMD_TRI:
                    begin
                        if (stat.tri_ok)
                            state_next = S_TPRD;
                    end
                    vna_pkg::CMD_READ:
                    begin
                        state_next = stat.slot_ok ? S_RARD : S_ZERO;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TPRD:
            begin
                // read a, b, c back to back; data lands in the cycle after its read
                ctl.sel     = cnt_reg[1:0];
                ctl.pos_cap = (cnt_reg != '0);
                ctl.cap_sel = cnt_reg[1:0] - 2'd1;
                if (cnt_reg == CNT_THREE)
                begin
                    cnt_next   = '0;
                    state_next = S_XMUL;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_XMUL:
            begin
                ctl.xmul   = 1'b1;
                ctl.k      = k_reg;
                state_next = S_XSUB;
            end
            S_XSUB:
            begin
                ctl.xsub = 1'b1;
                ctl.k    = k_reg;
                if (k_reg == vna_pkg::CRN_C)
                begin
                    k_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_XMUL;
                end
            end
            S_ARD:
            begin
                ctl.sel    = k_reg;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                ctl.sel    = k_reg;
                ctl.acc_wr = 1'b1;
                if (k_reg == vna_pkg::CRN_C)
                    state_next = S_IDLE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_ARD;
                end
            end
            S_RARD:
            begin
                ctl.sel    = vna_pkg::CRN_A;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                ctl.mag_cap = 1'b1;
                cnt_next    = '0;
                state_next  = S_SQ1;
            end
            S_SQ1, S_SQ2:
            begin
                ctl.sq_clr = (cnt_reg == '0);
                ctl.sq_mul = (cnt_reg != CNT_THREE);
                ctl.sq_add = (cnt_reg != '0);
                ctl.k      = cnt_reg[1:0];
                if (cnt_reg == CNT_THREE)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SQ1) ? S_THR : S_SQI;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_THR:
            begin
                state_next = (stat.big || !stat.thr_ok) ? S_NORM : S_ZERO;
            end
            S_NORM:
            begin
                if (stat.norm_done)
                    state_next = S_SQ2;
                else
                    ctl.norm_step = 1'b1;
            end
            S_SQI:
            begin
                ctl.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                ctl.sqrt_step = 1'b1;
                if (cnt_reg == CNT_SQRT_LAST)
                begin
                    cnt_next   = '0;
                    k_next     = '0;
                    state_next = S_DIVI;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_DIVI:
            begin
                ctl.div_init = 1'b1;
                ctl.k        = k_reg;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (cnt_reg == CNT_DIV_LAST)
                    state_next = S_DIVS;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_DIVS:
            begin
                ctl.div_store = 1'b1;
                ctl.k         = k_reg;
                if (k_reg == vna_pkg::CRN_C)
                    state_next = S_OUT;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DIVI;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (stat.out_free)
                begin
                    ctl.res_zero = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_dec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC) |-> $past(in_valid && in_ready))
        else $error("decode without an accepted beat");

    a_rmw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.acc_wr |-> ($past(ctl.sel) == ctl.sel))
        else $error("accumulator write to a slot other than the one read");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_store |-> ($past(state_reg) == S_DIV))
        else $error("quotient stored before division finished");

endmodule

/* rtl/vna_dp.sv */
// ============================================================================
// vna_dp
// Datapath: vertex stores, cross product, saturating accumulate, normalize.
// ============================================================================
module vna_dp #(
    parameter int MAX_VERTICES  = 1024,
    parameter int POSITION_BITS = 16,
    parameter int ACCUM_BITS    = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vna_pkg::THR_W-1:0]         cfg_wdata,
    input  logic [1:0]                        in_cmd,
    input  logic [vna_pkg::IDX_W-1:0]         in_index_a,
    input  logic [vna_pkg::IDX_W-1:0]         in_index_b,
    input  logic [vna_pkg::IDX_W-1:0]         in_index_c,
    input  logic signed [vna_pkg::POS_W-1:0]  in_pos_x,
    input  logic signed [vna_pkg::POS_W-1:0]  in_pos_y,
    input  logic signed [vna_pkg::POS_W-1:0]  in_pos_z,
    input  vna_pkg::vna_ctl_t                 ctl,
    output vna_pkg::vna_stat_t                stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [vna_pkg::IDX_W-1:0]         vertex_slot,
    output logic signed [vna_pkg::NRM_W-1:0]  normal_x,
    output logic signed [vna_pkg::NRM_W-1:0]  normal_y,
    output logic signed [vna_pkg::NRM_W-1:0]  normal_z,
    output logic                              has_normal
);

    localparam int PB     = POSITION_BITS;
    localparam int AB     = ACCUM_BITS;
    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DIF_W  = PB + 1;
    localparam int PRD_W  = 2 * DIF_W;
    localparam int CRS_W  = PRD_W + 1;
    localparam int NUM_W  = 47;
    localparam int REM_W  = vna_pkg::LEN_W + 1;
    localparam int QW     = vna_pkg::QUO_W;
    localparam logic signed [24:0] PMAX = 25'(2 ** (PB - 1) - 1);
    localparam logic signed [24:0] PMIN = -PMAX - 25'sd1;
    localparam logic [16:0] NV = 17'(MAX_VERTICES);

    // latched item
    logic [1:0]                       cmd_reg;
    logic [vna_pkg::IDX_W-1:0]        ia_reg, ib_reg, ic_reg;
    logic signed [vna_pkg::POS_W-1:0] pin_reg [3];

    logic [vna_pkg::THR_W-1:0] thr_reg;

    // stores
    logic [3*PB-1:0] pos_mem [MAX_VERTICES];
    logic [3*AB-1:0] acc_mem [MAX_VERTICES];
    logic [3*PB-1:0] pos_q;
    logic [3*AB-1:0] acc_q;

    logic [vna_pkg::IDX_W-1:0] idx;
    logic [ADDR_W-1:0]         addr;
    logic [PB-1:0]             psat [3];
    logic [3*AB-1:0]           acc_new;

    // triangle
    logic signed [PB-1:0]    crn_reg [3][3];
    logic signed [DIF_W-1:0] u [3];
    logic signed [DIF_W-1:0] v [3];
    logic signed [PRD_W-1:0] p1_reg, p2_reg;
    logic signed [CRS_W-1:0] crs_reg [3];

    // normalize
    logic [AB-1:0]              mag_reg [3];
    logic                       neg_reg [3];
    logic [AB-1:0]              m01, mx;
    logic [31:0]                mop;
    logic [vna_pkg::SUM_W-1:0]  prod_reg, sum_reg;
    logic [vna_pkg::SUM_W-1:0]  sv_reg, sres_reg, sbit_reg, st;
    logic [vna_pkg::LEN_W-1:0]  len;
    logic [NUM_W-1:0]           num;
    logic [REM_W-1:0]           rem_reg, rt;
    logic [QW-1:0]              nlow_reg, quo_reg, qsat;
    logic signed [vna_pkg::NRM_W-1:0] nrm_reg [3];

    // result register
    logic                              out_valid_reg;
    logic [vna_pkg::IDX_W-1:0]         slot_reg;
    logic signed [vna_pkg::NRM_W-1:0]  nx_reg, ny_reg, nz_reg;
    logic                              has_reg;

    always_comb
    begin
        unique case (ctl.sel)
            vna_pkg::CRN_A: idx = ia_reg;
            vna_pkg::CRN_B: idx = ib_reg;
            vna_pkg::CRN_C: idx = ic_reg;
            default:        idx = ia_reg;
        endcase
        addr = ADDR_W'(idx);
    end

    // clip positions to PB signed
    always_comb
    begin
        logic signed [24:0] pe;
        pe = '0;
        for (int k = 0; k < 3; k++)
        begin
            pe = 25'(pin_reg[k]);
            if (pe > PMAX)
                psat[k] = PB'(PMAX);
            else if (pe < PMIN)
                psat[k] = PB'(PMIN);
            else
                psat[k] = PB'(pe);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u[k] = DIF_W'(crn_reg[1][k]) - DIF_W'(crn_reg[0][k]);
            v[k] = DIF_W'(crn_reg[2][k]) - DIF_W'(crn_reg[0][k]);
        end
    end

    // saturating accumulate
    always_comb
    begin
        logic signed [AB-1:0] a;
        logic signed [AB:0]   s;
        a = '0;
        s = '0;
        for (int k = 0; k < 3; k++)
        begin
            a = $signed(acc_q[k*AB +: AB]);
            s = (AB+1)'(a) + (AB+1)'(crs_reg[k]);
            if (s[AB] != s[AB-1])
                acc_new[k*AB +: AB] = s[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
            else
                acc_new[k*AB +: AB] = s[AB-1:0];
        end
    end

    assign m01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign mx  = (m01 > mag_reg[2]) ? m01 : mag_reg[2];
    assign mop = (ctl.k == vna_pkg::CRN_C) ? mag_reg[2][31:0] :
                 (ctl.k == vna_pkg::CRN_B) ? mag_reg[1][31:0] : mag_reg[0][31:0];
    assign st  = sres_reg + sbit_reg;
    assign len = sres_reg[vna_pkg::LEN_W-1:0];
    assign num = NUM_W'({mop[30:0], 14'b0}) + NUM_W'(len >> 1);
    assign rt  = {rem_reg[REM_W-2:0], nlow_reg[QW-1]};
    assign qsat = (quo_reg > vna_pkg::ONE_Q14) ? vna_pkg::ONE_Q14 : quo_reg;

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.slot_ok   = ({7'b0, ia_reg} < NV);
        stat.tri_ok    = ({7'b0, ia_reg} < NV) && ({7'b0, ib_reg} < NV)
                         && ({7'b0, ic_reg} < NV);
        stat.big       = |mx[AB-1:20];
        stat.thr_ok    = (sum_reg <= vna_pkg::SUM_W'(thr_reg));
        stat.norm_done = ~|mx[AB-1:31] & mx[30];
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pos_wr)
            pos_mem[addr] <= {psat[2], psat[1], psat[0]};
        pos_q <= pos_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pos_wr)
            acc_mem[addr] <= '0;
        else if (ctl.acc_wr)
            acc_mem[addr] <= acc_new;
        acc_q <= acc_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (ctl.res_load || ctl.res_zero)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg    <= in_cmd;
            ia_reg     <= in_index_a;
            ib_reg     <= in_index_b;
            ic_reg     <= in_index_c;
            pin_reg[0] <= in_pos_x;
            pin_reg[1] <= in_pos_y;
            pin_reg[2] <= in_pos_z;
        end
        if (ctl.pos_cap)
            for (int k = 0; k < 3; k++)
                crn_reg[ctl.cap_sel][k] <= $signed(pos_q[k*PB +: PB]);
        if (ctl.xmul)
        begin
            unique case (ctl.k)
                vna_pkg::CRN_B:
                begin
                    p1_reg <= u[2] * v[0];
                    p2_reg <= u[0] * v[2];
                end
                vna_pkg::CRN_C:
                begin
                    p1_reg <= u[0] * v[1];
                    p2_reg <= u[1] * v[0];
                end
                default:
                begin
                    p1_reg <= u[1] * v[2];
                    p2_reg <= u[2] * v[1];
                end
            endcase
        end
        if (ctl.xsub)
            crs_reg[ctl.k] <= CRS_W'(p1_reg) - CRS_W'(p2_reg);
        if (ctl.mag_cap)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= acc_q[k*AB + AB - 1];
                mag_reg[k] <= acc_q[k*AB + AB - 1] ? (~acc_q[k*AB +: AB] + AB'(1))
                                                   : acc_q[k*AB +: AB];
            end
        end
        else if (ctl.norm_step)
        begin
            // right shifts truncate, same as one shift by the total
            for (int k = 0; k < 3; k++)
                mag_reg[k] <= (|mx[AB-1:31]) ? (mag_reg[k] >> 1) : (mag_reg[k] << 1);
        end
        if (ctl.sq_mul)
            prod_reg <= mop * mop;
        if (ctl.sq_clr)
            sum_reg <= '0;
        else if (ctl.sq_add)
            sum_reg <= sum_reg + prod_reg;
        if (ctl.sqrt_init)
        begin
            sv_reg   <= sum_reg;
            sres_reg <= '0;
            sbit_reg <= vna_pkg::SQRT_TOP;
        end
        else if (ctl.sqrt_step)
        begin
            if (sv_reg >= st)
            begin
                sv_reg   <= sv_reg - st;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_reg <= sres_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
        end
        if (ctl.div_init)
        begin
            // quotient fits 16 bits, so the top part starts below the divisor
            rem_reg  <= REM_W'(num >> QW);
            nlow_reg <= num[QW-1:0];
            quo_reg  <= '0;
        end
        else if (ctl.div_step)
        begin
            if (rt >= {1'b0, len})
            begin
                rem_reg <= rt - {1'b0, len};
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rt;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
            nlow_reg <= nlow_reg << 1;
        end
        if (ctl.div_store)
            nrm_reg[ctl.k] <= neg_reg[ctl.k] ? $signed(-qsat) : $signed(qsat);
        if (ctl.res_load)
        begin
            slot_reg <= ia_reg;
            nx_reg   <= nrm_reg[0];
            ny_reg   <= nrm_reg[1];
            nz_reg   <= nrm_reg[2];
            has_reg  <= 1'b1;
        end
        else if (ctl.res_zero)
        begin
            slot_reg <= ia_reg;
            nx_reg   <= '0;
            ny_reg   <= '0;
            nz_reg   <= '0;
            has_reg  <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex_slot = slot_reg;
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign has_normal  = has_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.res_load || ctl.res_zero) |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.res_zero |=> (out_valid_reg && !has_reg && nx_reg == '0
                          && ny_reg == '0 && nz_reg == '0))
        else $error("degenerate result not cleared");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sqrt_init |-> (~|mx[AB-1:31] && mx[30]))
        else $error("square root started on unnormalized magnitudes");

endmodule

/* rtl/vertex_normal_accumulator.sv */
// ============================================================================
// vertex_normal_accumulator
// Area-weighted vertex normals in fixed point over a slot store.
// ============================================================================
// One item is in work at a time. A load beat is accepted and then
// written. A triangle beat makes three position reads from the
// single-ported position memory, forms three cross-product components
// through one multiply/subtract pair, then makes three read-modify-write
// passes on the accumulator memory. A read beat whose normal turns out
// degenerate ends early with a zero result; otherwise the magnitudes
// shift one bit per cycle until normalized, the square root resolves
// one result bit per cycle, and each of the three components runs a
// restoring divide. A finished result sits in an output register, so
// the next beat is accepted while it waits to be taken. Reads of slots
// that were never loaded return undefined data.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES  = 1024,
    parameter int POSITION_BITS = 16,
    parameter int ACCUM_BITS    = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    vna_in_if.sink                     item_in,
    vna_out_if.source                  result_out,
    input  logic                       cfg_we,
    input  logic [vna_pkg::THR_W-1:0]  cfg_wdata
);

    vna_pkg::vna_ctl_t  ctl;
    vna_pkg::vna_stat_t stat;
    logic               in_ready;

    // sequencer: owns the handshake on the item side
    vna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    assign item_in.ready = in_ready;

    // stores, arithmetic and result register
    vna_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .POSITION_BITS (POSITION_BITS),
        .ACCUM_BITS    (ACCUM_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_cmd      (item_in.cmd),
        .in_index_a  (item_in.index_a),
        .in_index_b  (item_in.index_b),
        .in_index_c  (item_in.index_c),
        .in_pos_x    (item_in.pos_x),
        .in_pos_y    (item_in.pos_y),
        .in_pos_z    (item_in.pos_z),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .vertex_slot (result_out.vertex_slot),
        .normal_x    (result_out.normal_x),
        .normal_y    (result_out.normal_y),
        .normal_z    (result_out.normal_z),
        .has_normal  (result_out.has_normal)
    );

endmodule

/* tb/testbench.sv */
// ============================================================================
// Vertex normal accumulator testbench
// Drives load, triangle and read beats into the slot store and checks every
// returned unit normal against an in-bench fixed-point predictor, across
// several degenerate-threshold settings, saturation and output back-pressure.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] CMD_NONE = 2'd3;   // unused code, block ignores it
    localparam int  SLOTS      = 1 << vna_pkg::IDX_W;
    localparam int  CYCLE_CAP  = 1500000;
    localparam int  SETTLE     = 200;         // longer than a full read pass
    localparam int  HOLD_LEN   = 600;

    typedef struct {
        logic [1:0]                       cmd;
        logic [vna_pkg::IDX_W-1:0]        ia;
        logic [vna_pkg::IDX_W-1:0]        ib;
        logic [vna_pkg::IDX_W-1:0]        ic;
        logic signed [vna_pkg::POS_W-1:0] px;
        logic signed [vna_pkg::POS_W-1:0] py;
        logic signed [vna_pkg::POS_W-1:0] pz;
    } beat_t;

    typedef struct {
        logic [vna_pkg::IDX_W-1:0]        slot;
        logic signed [vna_pkg::NRM_W-1:0] nx;
        logic signed [vna_pkg::NRM_W-1:0] ny;
        logic signed [vna_pkg::NRM_W-1:0] nz;
        logic                             has;
    } normal_t;

    // Scoreboard: mirrors the slot store and holds the normals still owed.
    class normal_board;
        longint                    pos [SLOTS][3];
        longint                    acc [SLOTS][3];
        logic [vna_pkg::THR_W-1:0] thr;
        normal_t                   owed [$];
        int                        errors;
        int                        checked;
        int                        flat_reads;

        function new();
            thr = '0;
            errors = 0;
            checked = 0;
            flat_reads = 0;
        endfunction

        function longint sat_acc(longint a, longint b);
            longint hi;
            longint s;
            hi = (64'sd1 <<< 39) - 1;
            s  = a + b;
            if (s > hi) return hi;
            if (s < -hi - 1) return -hi - 1;
            return s;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function normal_t unit_normal(logic [vna_pkg::IDX_W-1:0] slot);
            normal_t         r;
            longint unsigned mag [3];
            bit              neg [3];
            longint unsigned mx;
            longint unsigned s;
            longint unsigned len;
            longint unsigned q;
            logic [127:0]    sq;
            r.slot = slot;
            r.nx = '0;
            r.ny = '0;
            r.nz = '0;
            r.has = 1'b0;
            sq = '0;
            mx = 0;
            for (int k = 0; k < 3; k++)
            begin
                neg[k] = acc[slot][k] < 0;
                mag[k] = neg[k] ? longint'(-acc[slot][k]) : longint'(acc[slot][k]);
                sq += 128'(mag[k]) * 128'(mag[k]);
                if (mag[k] > mx) mx = mag[k];
            end
            if (sq <= 128'(thr)) return r;
            // bring the largest magnitude into [2^30, 2^31)
            while (mx >= (64'd1 << 31))
            begin
                mx >>= 1;
                for (int k = 0; k < 3; k++) mag[k] >>= 1;
            end
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1;
                for (int k = 0; k < 3; k++) mag[k] <<= 1;
            end
            s = 0;
            for (int k = 0; k < 3; k++) s += mag[k] * mag[k];
            len = root_floor(s);
            for (int k = 0; k < 3; k++)
            begin
                q = (mag[k] * 16384 + len / 2) / len;
                if (q > 16384) q = 16384;
                if (neg[k]) q = -q;
                case (k)
                    0: r.nx = q[15:0];
                    1: r.ny = q[15:0];
                    default: r.nz = q[15:0];
                endcase
            end
            r.has = 1'b1;
            return r;
        endfunction

        function void note_beat(beat_t b);
            longint u [3];
            longint v [3];
            longint n [3];
            case (b.cmd)
                vna_pkg::CMD_LOAD:
                begin
                    pos[b.ia][0] = b.px;
                    pos[b.ia][1] = b.py;
                    pos[b.ia][2] = b.pz;
                    for (int k = 0; k < 3; k++) acc[b.ia][k] = 0;
                end
                vna_pkg::CMD_TRI:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        u[k] = pos[b.ib][k] - pos[b.ia][k];
                        v[k] = pos[b.ic][k] - pos[b.ia][k];
                    end
                    n[0] = u[1] * v[2] - u[2] * v[1];
                    n[1] = u[2] * v[0] - u[0] * v[2];
                    n[2] = u[0] * v[1] - u[1] * v[0];
                    for (int k = 0; k < 3; k++)
                    begin
                        acc[b.ia][k] = sat_acc(acc[b.ia][k], n[k]);
                        acc[b.ib][k] = sat_acc(acc[b.ib][k], n[k]);
                        acc[b.ic][k] = sat_acc(acc[b.ic][k], n[k]);
                    end
                end
                vna_pkg::CMD_READ: owed = {owed, unit_normal(b.ia)};
                default: ;
            endcase
        endfunction

        task flag_mismatch(string what, longint got, longint want);
            errors++;
            $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        endtask

        task check_result(normal_t got);
            normal_t want;
            if (owed.size() == 0)
            begin
                flag_mismatch("unexpected result for slot", got.slot, -1);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (!want.has) flat_reads++;
            if (got.slot !== want.slot) flag_mismatch("vertex_slot", got.slot, want.slot);
            if (got.nx !== want.nx) flag_mismatch("normal_x", got.nx, want.nx);
            if (got.ny !== want.ny) flag_mismatch("normal_y", got.ny, want.ny);
            if (got.nz !== want.nz) flag_mismatch("normal_z", got.nz, want.nz);
            if (got.has !== want.has) flag_mismatch("has_normal", got.has, want.has);
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [vna_pkg::THR_W-1:0] cfg_wdata;

    vna_in_if  item_ch ();
    vna_out_if res_ch ();

    vertex_normal_accumulator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (res_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    normal_board board = new();

    // stimulus bookkeeping
    bit  loaded [SLOTS];
    int  load_order [$];      // slots in the order they were first loaded
    bit  steady;              // no random idling on either side
    bit  hold_req;            // ask the receiver for a long hold-off
    int  hold_left;
    int  cycles;
    int  n_load, n_tri, n_read, n_junk;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: random ready, a long hold-off on request, and the check.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            board.check_result(normal_t'{res_ch.vertex_slot, res_ch.normal_x,
                                         res_ch.normal_y, res_ch.normal_z,
                                         res_ch.has_normal});
        end
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d normals still owed",
                     cycles, board.owed.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // One beat on the item channel; valid stays up across back-to-back beats.
    task send_beat(beat_t b);
        if (!steady)
        begin
            while ($urandom_range(99) < 19)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_ch.cmd     <= b.cmd;
        item_ch.index_a <= b.ia;
        item_ch.index_b <= b.ib;
        item_ch.index_c <= b.ic;
        item_ch.pos_x   <= b.px;
        item_ch.pos_y   <= b.py;
        item_ch.pos_z   <= b.pz;
        item_ch.valid   <= 1'b1;
        do @(posedge clk); while (!item_ch.ready);
        board.note_beat(b);
        case (b.cmd)
            vna_pkg::CMD_LOAD: n_load++;
            vna_pkg::CMD_TRI:  n_tri++;
            vna_pkg::CMD_READ: n_read++;
            default:           n_junk++;
        endcase
    endtask

    function beat_t noise_beat(logic [1:0] cmd);
        beat_t b;
        b.cmd = cmd;
        b.ia = vna_pkg::IDX_W'($urandom());
        b.ib = vna_pkg::IDX_W'($urandom());
        b.ic = vna_pkg::IDX_W'($urandom());
        b.px = vna_pkg::POS_W'($urandom());
        b.py = vna_pkg::POS_W'($urandom());
        b.pz = vna_pkg::POS_W'($urandom());
        return b;
    endfunction

    task load_slot(logic [vna_pkg::IDX_W-1:0] slot, logic signed [vna_pkg::POS_W-1:0] x,
                   logic signed [vna_pkg::POS_W-1:0] y,
                   logic signed [vna_pkg::POS_W-1:0] z);
        beat_t b;
        b = noise_beat(vna_pkg::CMD_LOAD);
        b.ia = slot;
        b.px = x;
        b.py = y;
        b.pz = z;
        send_beat(b);
        if (!loaded[slot]) load_order = {load_order, int'(slot)};
        loaded[slot] = 1'b1;
    endtask

    task add_tri(logic [vna_pkg::IDX_W-1:0] a, logic [vna_pkg::IDX_W-1:0] b2,
                 logic [vna_pkg::IDX_W-1:0] c);
        beat_t b;
        b = noise_beat(vna_pkg::CMD_TRI);
        b.ia = a;
        b.ib = b2;
        b.ic = c;
        send_beat(b);
    endtask

    task read_slot(logic [vna_pkg::IDX_W-1:0] slot);
        beat_t b;
        b = noise_beat(vna_pkg::CMD_READ);
        b.ia = slot;
        send_beat(b);
    endtask

    // Let everything owed come back, then give the block time to finish any
    // load or triangle still in flight before touching the register.
    task drain;
        item_ch.valid <= 1'b0;
        while (board.owed.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_threshold(logic [vna_pkg::THR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.thr = value;
    endtask

    function logic [vna_pkg::POS_W-1:0] rand_coord();
        // half the time small, so low thresholds actually bite
        if ($urandom_range(1)) return vna_pkg::POS_W'($signed($urandom_range(255)) - 128);
        return vna_pkg::POS_W'($urandom());
    endfunction

    // Corners lean toward recently loaded slots so normals build up.
    function logic [vna_pkg::IDX_W-1:0] pick_slot();
        int n;
        n = load_order.size();
        if (n > 24 && $urandom_range(99) < 70)
            return vna_pkg::IDX_W'(load_order[$urandom_range(n - 1, n - 24)]);
        return vna_pkg::IDX_W'(load_order[$urandom_range(n - 1)]);
    endfunction

    task random_mix(int count);
        int r;
        logic [vna_pkg::IDX_W-1:0] a;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (load_order.size() < 3 || r < 25)
            begin
                load_slot(vna_pkg::IDX_W'($urandom()), rand_coord(), rand_coord(),
                          rand_coord());
            end
            else if (r < 65)
            begin
                a = pick_slot();
                if ($urandom_range(9) == 0) add_tri(a, a, pick_slot());
                else add_tri(a, pick_slot(), pick_slot());
            end
            else if (r < 95)
            begin
                read_slot(pick_slot());
            end
            else
            begin
                send_beat(noise_beat(CMD_NONE));
            end
        end
    endtask

    // Same large triangle over and over until the corner sums pin at the
    // accumulator limit; flip the winding for the negative limit.
    task saturate(bit flip);
        logic [vna_pkg::IDX_W-1:0] s [3];
        for (int k = 0; k < 3; k++) s[k] = vna_pkg::IDX_W'($urandom());
        while (s[1] == s[0]) s[1] = vna_pkg::IDX_W'($urandom());
        while (s[2] == s[0] || s[2] == s[1]) s[2] = vna_pkg::IDX_W'($urandom());
        load_slot(s[0], 16'sh8000, 16'sh8000, 16'sh0000);
        load_slot(s[1], 16'sh7FFF, 16'sh8000, 16'sh0000);
        load_slot(s[2], 16'sh8000, 16'sh7FFF, 16'sh0000);
        for (int i = 0; i < 130; i++)
        begin
            if (flip) add_tri(s[0], s[2], s[1]);
            else add_tri(s[0], s[1], s[2]);
        end
        for (int k = 0; k < 3; k++) read_slot(s[k]);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.cmd = vna_pkg::CMD_LOAD;
        item_ch.index_a = '0;
        item_ch.index_b = '0;
        item_ch.index_c = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.pos_z = '0;
        res_ch.ready = 1'b0;
        steady = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        cycles = 0;
        n_load = 0;
        n_tri = 0;
        n_read = 0;
        n_junk = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme slots and coordinates, every command, threshold
        // at its reset value of zero
        load_slot(10'd0, 16'sh7FFF, 16'sh8000, 16'sh0000);
        load_slot(10'd1023, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        load_slot(10'd512, 16'sh0001, 16'shFFFF, 16'sh8000);
        read_slot(10'd0);                       // freshly loaded: degenerate
        add_tri(10'd0, 10'd1023, 10'd512);
        add_tri(10'd512, 10'd1023, 10'd0);      // opposite winding on the set
        add_tri(10'd0, 10'd0, 10'd1023);        // repeated corner adds nothing
        read_slot(10'd0);
        read_slot(10'd1023);
        read_slot(10'd512);
        send_beat(noise_beat(CMD_NONE));        // unknown command, no result
        load_slot(10'd341, 16'sh0010, 16'sh0000, 16'sh0000);
        load_slot(10'd682, 16'sh0000, 16'sh0010, 16'sh0000);
        add_tri(10'd341, 10'd682, 10'd512);
        read_slot(10'd341);
        load_slot(10'd0, 16'sh0000, 16'sh0000, 16'sh0000); // reload clears sums
        read_slot(10'd0);
        read_slot(10'd682);
        drain();

        // threshold at its top: small normals go degenerate
        write_threshold({vna_pkg::THR_W{1'b1}});
        hold_req = 1'b1;                        // output stalls, input backs up
        random_mix(170);
        saturate(1'b0);
        drain();

        // low thresholds, no idling on either side
        write_threshold(vna_pkg::THR_W'(1) << $urandom_range(39));
        steady = 1'b1;
        random_mix(170);
        steady = 1'b0;
        drain();

        write_threshold(vna_pkg::THR_W'({$urandom(), $urandom()}));
        random_mix(170);
        saturate(1'b1);
        drain();

        write_threshold('0);
        random_mix(170);
        drain();

        $display("beats: %0d loads, %0d triangles, %0d reads, %0d unknown; thresholds 0..max",
                 n_load, n_tri, n_read, n_junk);
        $display("normals checked: %0d (%0d degenerate), mismatches: %0d",
                 board.checked, board.flat_reads, board.errors);
        if (board.errors == 0 && board.owed.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
